### rtl/nppf_pkg.sv
// ----------------------------------------------------------------------------
// nppf_pkg
// Shared types and codes for the nibble-prefixed frame parser: prefix and
// message codes, the parse phase and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package nppf_pkg;

  localparam int unsigned NibW  = 4;
  localparam int unsigned ByteW = 8;
  localparam int unsigned WordW = 16;

  localparam logic [NibW-1:0] PrefixMsgType = 4'd5;
  localparam logic [NibW-1:0] PrefixSeq     = 4'd6;
  localparam logic [NibW-1:0] PrefixByte    = 4'd4;
  localparam logic [NibW-1:0] PrefixEom     = 4'd3;

  localparam logic [NibW-1:0] MsgCurPos   = 4'd3;
  localparam logic [NibW-1:0] MsgDeviceId = 4'd4;

  localparam logic [1:0] LastNibble = 2'd3;

  typedef enum logic [2:0] {
    PH_TYPE = 3'd0,
    PH_SEQ  = 3'd1,
    PH_BYTE = 3'd2,
    PH_WORD = 3'd3,
    PH_EOM  = 3'd4
  } phase_e;

  typedef struct packed {
    logic                    status;
    logic [NibW-1:0]         msg_code;
    logic [NibW-1:0]         seq_num;
    logic [NibW-1:0]         byte_field;
    logic signed [WordW-1:0] position_word;
  } result_t;

endpackage

`default_nettype wire

### rtl/nibble_prefixed_frame_parser.sv
// ----------------------------------------------------------------------------
// nibble_prefixed_frame_parser
// Follows nibble-prefixed frames (type, sequence, byte, optional position
// word, end of message) and reports one result per finished or bad frame.
//
//   channel  direction  handshake                 payload
//   in       sink       in_valid_i / in_stall_o   rx_byte_i
//   out      source     out_valid_o / out_stall_i status_o, msg_code_o,
//                                                 seq_num_o, byte_field_o,
//                                                 position_word_o
//
// one byte accepted per cycle while in_stall_o is low; a result shows on the
// outputs the cycle after the byte that closes its frame is accepted
// the single result register sets the rate: input stalls only while a result
// is held and the output is stalled
// reset is asynchronous, active low, and returns to waiting for a type byte
// ----------------------------------------------------------------------------
`default_nettype none

module nibble_prefixed_frame_parser
  import nppf_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [ByteW-1:0]  rx_byte_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic                   status_o,
  output logic [NibW-1:0]        msg_code_o,
  output logic [NibW-1:0]        seq_num_o,
  output logic [NibW-1:0]        byte_field_o,
  output logic signed [WordW-1:0] position_word_o
);

  logic    accept;
  logic    emit;
  logic    busy;
  result_t fsm_res;
  result_t out_res;

  assign in_stall_o = busy;
  assign accept     = in_valid_i && !busy;

  nppf_fsm u_fsm (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .rx_byte_i (rx_byte_i),
    .emit_o    (emit),
    .res_o     (fsm_res)
  );

  nppf_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept && emit),
    .res_i       (fsm_res),
    .busy_o      (busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (out_res)
  );

  assign status_o        = out_res.status;
  assign msg_code_o      = out_res.msg_code;
  assign seq_num_o       = out_res.seq_num;
  assign byte_field_o    = out_res.byte_field;
  assign position_word_o = out_res.position_word;

endmodule

`default_nettype wire

### rtl/nppf_fsm.sv
// ----------------------------------------------------------------------------
// nppf_fsm
// Frame tracking state machine: keeps the phase and the captured fields and
// flags a result for the byte presented when the frame ends or goes wrong.
// ----------------------------------------------------------------------------
`default_nettype none

module nppf_fsm
  import nppf_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             accept_i,
  input  wire logic [ByteW-1:0] rx_byte_i,
  output logic                  emit_o,
  output result_t               res_o
);

  phase_e              phase_q, phase_d;
  logic [NibW-1:0]     code_q, code_d;
  logic [NibW-1:0]     seq_q, seq_d;
  logic [NibW-1:0]     byte_q, byte_d;
  logic [WordW-1:0]    word_q, word_d;
  logic [1:0]          cnt_q, cnt_d;

  logic [NibW-1:0] prefix;
  logic [NibW-1:0] data;
  logic            code_ok;

  assign prefix  = rx_byte_i[ByteW-1:NibW];
  assign data    = rx_byte_i[NibW-1:0];
  assign code_ok = (data == MsgCurPos) || (data == MsgDeviceId);

  // next state
  always_comb begin
    phase_d = phase_q;
    code_d  = code_q;
    seq_d   = seq_q;
    byte_d  = byte_q;
    word_d  = word_q;
    cnt_d   = cnt_q;
    unique case (phase_q)
      PH_SEQ: begin
        if (prefix == PrefixSeq) begin
          seq_d   = data;
          phase_d = PH_BYTE;
        end else begin
          phase_d = PH_TYPE;
        end
      end
      PH_BYTE: begin
        if (prefix == PrefixByte) begin
          byte_d  = data;
          phase_d = (code_q == MsgCurPos) ? PH_WORD : PH_EOM;
        end else begin
          phase_d = PH_TYPE;
        end
      end
      PH_WORD: begin
        // word nibble prefixes go unchecked
        word_d = {word_q[WordW-NibW-1:0], data};
        if (cnt_q == LastNibble) begin
          cnt_d   = '0;
          phase_d = PH_EOM;
        end else begin
          cnt_d = cnt_q + 2'd1;
        end
      end
      PH_EOM: begin
        phase_d = PH_TYPE;
      end
      default: begin
        code_d = (prefix == PrefixMsgType) ? data : '0;
        seq_d  = '0;
        byte_d = '0;
        word_d = '0;
        cnt_d  = '0;
        phase_d = ((prefix == PrefixMsgType) && code_ok) ? PH_SEQ : PH_TYPE;
      end
    endcase
  end

  // result for the byte on the input
  always_comb begin
    emit_o              = 1'b0;
    res_o.status        = 1'b1;
    res_o.msg_code      = code_q;
    res_o.seq_num       = seq_q;
    res_o.byte_field    = byte_q;
    res_o.position_word = word_q;
    unique case (phase_q)
      PH_SEQ:  emit_o = (prefix != PrefixSeq);
      PH_BYTE: emit_o = (prefix != PrefixByte);
      PH_WORD: emit_o = 1'b0;
      PH_EOM: begin
        emit_o       = 1'b1;
        res_o.status = (prefix != PrefixEom);
      end
      default: begin
        emit_o              = !((prefix == PrefixMsgType) && code_ok);
        res_o.msg_code      = (prefix == PrefixMsgType) ? data : '0;
        res_o.seq_num       = '0;
        res_o.byte_field    = '0;
        res_o.position_word = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TYPE;
      code_q  <= '0;
      seq_q   <= '0;
      byte_q  <= '0;
      word_q  <= '0;
      cnt_q   <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      code_q  <= code_d;
      seq_q   <= seq_d;
      byte_q  <= byte_d;
      word_q  <= word_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

`default_nettype wire

### rtl/nppf_out_reg.sv
// ----------------------------------------------------------------------------
// nppf_out_reg
// Result register: holds one result until the downstream side takes it, and
// takes a new one in the same cycle as the old one leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module nppf_out_reg
  import nppf_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    load_i,
  input  wire result_t res_i,
  output logic         busy_o,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  output result_t      res_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  assign busy_o      = valid_q && out_stall_i;
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (valid_q && !out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

`default_nettype wire

### rtl/nppf_checker.sv
// ----------------------------------------------------------------------------
// nppf_checker
// Port-level checks on the frame parser: request hold, back-pressure and the
// consistency of reported frames.
// ----------------------------------------------------------------------------
`default_nettype none

module nppf_checker
  import nppf_pkg::*;
(
  input wire logic                    clk_i,
  input wire logic                    rst_ni,
  input wire logic                    in_valid_i,
  input wire logic                    in_stall_o,
  input wire logic [ByteW-1:0]        rx_byte_i,
  input wire logic                    out_valid_o,
  input wire logic                    out_stall_i,
  input wire logic                    status_o,
  input wire logic [NibW-1:0]         msg_code_o,
  input wire logic [NibW-1:0]         seq_num_o,
  input wire logic [NibW-1:0]         byte_field_o,
  input wire logic signed [WordW-1:0] position_word_o
);

  // a stalled byte request keeps its value
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(rx_byte_i))
    else $error("byte request changed while stalled");

  // a stalled request stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result request dropped while stalled");

  // a held, stalled result blocks new bytes
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("byte accepted while result register full");

  // an unsupported type is ill formed, with nothing captured after it
  a_bad_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (msg_code_o != MsgCurPos) && (msg_code_o != MsgDeviceId) |->
      status_o && (seq_num_o == '0) && (byte_field_o == '0))
    else $error("unsupported type reported as good or with fields");

  // only position frames carry a word
  a_word_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (msg_code_o != MsgCurPos) |-> position_word_o == '0)
    else $error("position word on a non-position frame");

endmodule

bind nibble_prefixed_frame_parser nppf_checker u_nppf_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .rx_byte_i       (rx_byte_i),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .status_o        (status_o),
  .msg_code_o      (msg_code_o),
  .seq_num_o       (seq_num_o),
  .byte_field_o    (byte_field_o),
  .position_word_o (position_word_o)
);

`default_nettype wire
